/* rtl/tt800_pkg.sv */
// package: types, constants and helper functions for the tt800 random bit source
package tt800_pkg;

   localparam int unsigned WORDS      = 25;
   localparam int unsigned SHIFT      = 7;
   localparam int unsigned LAG        = WORDS - SHIFT;
   localparam int unsigned BLOCK_BITS = WORDS * 32;

   localparam logic [31:0] TWIST    = 32'h8ebfd028;
   localparam logic [31:0] TEMPER_B = 32'h2b5b2500;
   localparam logic [31:0] TEMPER_C = 32'hdb8b0000;
   localparam logic [15:0] ZERO_LIMIT = 16'hffff;

   localparam logic [1:0] KIND_TAKE   = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_SEED   = 2'd2;

   localparam logic [31:0] SEED_TABLE [WORDS] = '{
      32'h95f24dab, 32'h0b685215, 32'he76ccae7, 32'haf3ec239, 32'h715fad23,
      32'h24a590ad, 32'h69e4b5ef, 32'hbf456141, 32'h96bc1b7b, 32'ha7bdf825,
      32'hc1de75b7, 32'h8858a9c9, 32'h2da87693, 32'hb657f9dd, 32'hffdc8a9f,
      32'h8121da71, 32'h8b823ecb, 32'h885d05f5, 32'h4e20cd47, 32'h5a9ad5d9,
      32'h512c0c03, 32'hea857ccd, 32'h4cc1d30f, 32'h8891a8a1, 32'ha6b7aadb
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  bit_count;
      logic        skip_one;
      logic [4:0]  seed_index;
      logic [31:0] seed_word;
   } req_type;

   typedef struct packed {
      logic [31:0] bits;
      logic [15:0] zero_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FETCH,
      S_CHUNK,
      S_REGEN_RD,
      S_REGEN_WR,
      S_DONE
   } state_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 16);
      return y;
   endfunction

   // index of the lowest set bit, value nonzero
   function automatic logic [4:0] trailing_zeros(input logic [31:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) n = 5'(i);
      end
      return n;
   endfunction

endpackage

/* rtl/tt800_random_bit_source.sv */
// top level: tt800 random bit source with its state held in a two-read-port word memory
//
// The 25 generator words live in a memory with registered reads. After reset a fill
// pass writes the default seed table with busy high. A transaction is taken when start
// is high and busy low; its result appears for exactly one cycle with rsp_valid and
// cannot be held off. Seed loads, the unused kind and takes of zero bits go straight
// to the result. Taking bits and the bit search fetch and then process one tempered
// word at a time. Whenever the 800-bit block runs out, the next word fetch first
// regenerates all 25 words, a read then a write-back per word, and the fetch is then
// repeated.
module tt800_random_bit_source (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tt800_pkg::req_type  req_data,
   output logic                rsp_valid,
   output tt800_pkg::rsp_type  rsp_data
);
   import tt800_pkg::*;

   logic [31:0] words_ff [WORDS];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic [4:0]  rd_a_addr, rd_b_addr;
   logic        wr_en;
   logic [4:0]  wr_addr;
   logic [31:0] wr_data;

   state_type   state_ff, state_in;
   logic [9:0]  pos_ff, pos_in;
   logic [5:0]  n_ff, n_in;
   logic [5:0]  got_ff, got_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        skip_ff, skip_in;
   logic [1:0]  kind_ff, kind_in;
   logic [4:0]  regen_ff, regen_in;
   logic [4:0]  init_ff, init_in;

   logic        accept;
   logic [5:0]  n_cap;
   logic [31:0] tempered, chunk, mask;
   logic [4:0]  off;
   logic [5:0]  avail, remaining, take;
   logic [5:0]  zeros;
   logic [15:0] need;
   logic        chunk_done;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = '{bits: acc_ff, zero_count: cnt_ff};

   assign n_cap = (req_data.bit_count > 6'd32) ? 6'd32 : req_data.bit_count;

   // chunk arithmetic on the word fetched in the previous cycle
   assign tempered  = temper(rd_a_ff);
   assign off       = pos_ff[4:0];
   assign chunk     = tempered >> off;
   assign avail     = 6'd32 - {1'b0, off};
   assign remaining = n_ff - got_ff;
   assign take      = (remaining < avail) ? remaining : avail;
   assign mask      = ~({32{1'b1}} << take);
   assign zeros     = (chunk == '0) ? avail : {1'b0, trailing_zeros(chunk)};
   assign need      = ZERO_LIMIT - cnt_ff;

   always_comb begin
      if (kind_ff == KIND_TAKE) begin
         chunk_done = ((got_ff + take) == n_ff);
      end else begin
         chunk_done = ({10'd0, zeros} >= need) || (chunk != '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (init_ff == 5'(WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_SEARCH) begin
                  state_in = S_FETCH;
               end else if (req_data.kind == KIND_TAKE && n_cap != '0) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FETCH: begin
            if (pos_ff >= 10'(BLOCK_BITS)) state_in = S_REGEN_RD;
            else state_in = S_CHUNK;
         end
         S_CHUNK: begin
            state_in = chunk_done ? S_DONE : S_FETCH;
         end
         S_REGEN_RD: state_in = S_REGEN_WR;
         S_REGEN_WR: begin
            state_in = (regen_ff == 5'(WORDS - 1)) ? S_FETCH : S_REGEN_RD;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      pos_in    = pos_ff;
      n_in      = n_ff;
      got_in    = got_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      skip_in   = skip_ff;
      kind_in   = kind_ff;
      regen_in  = regen_ff;
      init_in   = init_ff;
      rd_a_addr = pos_ff[9:5];
      rd_b_addr = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff;
            wr_data = SEED_TABLE[init_ff];
            init_in = init_ff + 5'd1;
         end
         S_IDLE: begin
            if (accept) begin
               kind_in = req_data.kind;
               n_in    = n_cap;
               skip_in = req_data.skip_one;
               got_in  = '0;
               acc_in  = '0;
               cnt_in  = '0;
               if (req_data.kind == KIND_SEED) begin
                  pos_in = '0;
                  if (req_data.seed_index < 5'(WORDS)) begin
                     wr_en   = 1'b1;
                     wr_addr = req_data.seed_index;
                     wr_data = req_data.seed_word;
                  end
               end
            end
         end
         S_FETCH: begin
            regen_in = '0;
         end
         S_CHUNK: begin
            if (kind_ff == KIND_TAKE) begin
               acc_in = acc_ff | ((chunk & mask) << got_ff);
               got_in = got_ff + take;
               pos_in = pos_ff + {4'd0, take};
            end else if ({10'd0, zeros} >= need) begin
               // zero count saturates, found bit not consumed
               cnt_in = ZERO_LIMIT;
               pos_in = pos_ff + need[9:0];
            end else begin
               cnt_in = cnt_ff + {10'd0, zeros};
               pos_in = pos_ff + {4'd0, zeros}
                        + {9'd0, (chunk != '0) && skip_ff};
            end
         end
         S_REGEN_RD: begin
            rd_a_addr = regen_ff;
            rd_b_addr = (regen_ff < 5'(LAG)) ? regen_ff + 5'(SHIFT) : regen_ff - 5'(LAG);
         end
         S_REGEN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = regen_ff;
            wr_data  = rd_b_ff ^ (rd_a_ff >> 1) ^ (rd_a_ff[0] ? TWIST : 32'd0);
            regen_in = regen_ff + 5'd1;
            if (regen_ff == 5'(WORDS - 1)) pos_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) words_ff[wr_addr] <= wr_data;
      rd_a_ff <= words_ff[rd_a_addr];
      rd_b_ff <= words_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pos_ff   <= '0;
         init_ff  <= '0;
         regen_ff <= '0;
         kind_ff  <= KIND_TAKE;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         init_ff  <= init_in;
         regen_ff <= regen_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      got_ff  <= got_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      skip_ff <= skip_in;
   end

endmodule

/* verif/tt800_draw_checker.sv */
// checker for the tt800 random bit source: predicts each draw and compares the results
`timescale 1ns / 100ps

module tt800_draw_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  tt800_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  tt800_pkg::rsp_type rsp_data,
   input  logic               wrap_up,
   output int                 fail_count,
   output int                 draws_waiting,
   output int                 draws_checked,
   output int                 search_limit_hits
);
   import tt800_pkg::*;

   logic [31:0] gen_words [WORDS];
   int unsigned block_pos;
   rsp_type     draws_due [$];
   int          mismatches;
   int          checked;
   int          limit_hits;
   bit          leftovers_counted;

   function automatic logic [31:0] tempered(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ ((w << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      return y ^ (y >> 16);
   endfunction

   // full regeneration; the upper words feed from the freshly rewritten low words
   function automatic void twist_block();
      logic [31:0] w;
      int unsigned src;
      for (int i = 0; i < WORDS; i++) begin
         src = (i < LAG) ? i + SHIFT : i - LAG;
         w = gen_words[i];
         gen_words[i] = gen_words[src] ^ (w >> 1) ^ (w[0] ? TWIST : 32'h0);
      end
      block_pos = 0;
   endfunction

   // unused bits of the current tempered word, right-aligned
   function automatic logic [31:0] fresh_bits(output int unsigned avail);
      int unsigned off;
      if (block_pos >= BLOCK_BITS) twist_block();
      off = block_pos % 32;
      avail = 32 - off;
      return tempered(gen_words[(block_pos / 32) % WORDS]) >> off;
   endfunction

   function automatic logic [31:0] take_bits(input int unsigned wanted);
      logic [31:0] acc;
      logic [31:0] chunk;
      int unsigned got;
      int unsigned avail;
      int unsigned step;
      acc = '0;
      got = 0;
      if (wanted > 32) wanted = 32;
      while (got < wanted) begin
         chunk = fresh_bits(avail);
         step = wanted - got;
         if (step > avail) step = avail;
         if (step < 32) chunk &= (32'h1 << step) - 32'h1;
         acc |= chunk << got;
         got += step;
         block_pos += step;
      end
      return acc;
   endfunction

   function automatic logic [15:0] search_one(input logic skip);
      logic [31:0] chunk;
      logic [15:0] found;
      int unsigned zeros;
      int unsigned avail;
      int unsigned run;
      int unsigned room;
      bit          done;
      zeros = 0;
      found = '0;
      done = 0;
      while (!done) begin
         chunk = fresh_bits(avail);
         run = 0;
         if (chunk == 0) run = avail;
         else while (!chunk[run]) run++;
         room = ZERO_LIMIT - zeros;
         if (run >= room) begin
            // saturated: exactly the counted zeros are consumed, the one bit is not
            block_pos += room;
            limit_hits++;
            found = ZERO_LIMIT;
            done = 1;
         end else begin
            zeros += run;
            block_pos += run;
            if (chunk != 0) begin
               if (skip) block_pos += 1;
               found = 16'(zeros);
               done = 1;
            end
         end
      end
      return found;
   endfunction

   function automatic rsp_type predict_draw(input req_type rq);
      rsp_type r;
      r = '0;
      case (rq.kind)
         KIND_TAKE:   r.bits = take_bits(rq.bit_count);
         KIND_SEARCH: r.zero_count = search_one(rq.skip_one);
         KIND_SEED: begin
            if (rq.seed_index < WORDS) gen_words[rq.seed_index] = rq.seed_word;
            block_pos = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (gen_words[i]) gen_words[i] = SEED_TABLE[i];
         block_pos = 0;
         draws_due.delete();
      end else begin
         if (rsp_valid) begin
            if (draws_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: bits=%h zero_count=%0d",
                           $realtime, rsp_data.bits, rsp_data.zero_count);
            end else begin
               want = draws_due.pop_front();
               checked++;
               if (rsp_data.bits !== want.bits || rsp_data.zero_count !== want.zero_count)
               begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch bits exp %h got %h, zero_count exp %0d got %0d",
                              $realtime, want.bits, rsp_data.bits,
                              want.zero_count, rsp_data.zero_count);
               end
            end
         end
         if (start && !busy) draws_due.push_back(predict_draw(req_data));
         if (wrap_up && !leftovers_counted) begin
            leftovers_counted = 1;
            if (draws_due.size() != 0) begin
               mismatches += draws_due.size();
               $display("%0d expected results never arrived", draws_due.size());
            end
         end
      end
      fail_count        <= mismatches;
      draws_waiting     <= draws_due.size();
      draws_checked     <= checked;
      search_limit_hits <= limit_hits;
   end

endmodule

/* verif/tb.sv */
// testbench top for the tt800 random bit source: clock, reset, request stimulus, verdict
`timescale 1ns / 100ps

module tb;
   import tt800_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 60000;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    wrap_up  = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int draws_waiting;
   int draws_checked;
   int search_limit_hits;
   int kind_seen [4];
   int gap_mode = 1;

   tt800_random_bit_source dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   tt800_draw_checker draw_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .wrap_up           (wrap_up),
      .fail_count        (fail_count),
      .draws_waiting     (draws_waiting),
      .draws_checked     (draws_checked),
      .search_limit_hits (search_limit_hits)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type make_request(input logic [1:0] kind, input logic [5:0] count,
                                            input logic skip, input logic [4:0] index,
                                            input logic [31:0] word);
      req_type rq;
      rq.kind       = kind;
      rq.bit_count  = count;
      rq.skip_one   = skip;
      rq.seed_index = index;
      rq.seed_word  = word;
      return rq;
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int pick;
      rq = make_request(2'($urandom), 6'($urandom), 1'($urandom), 5'($urandom), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         rq.kind = KIND_TAKE;
         case ($urandom_range(0, 9))
            0: rq.bit_count = '0;
            1: rq.bit_count = 6'($urandom_range(33, 63));
            default: rq.bit_count = 6'($urandom_range(1, 32));
         endcase
      end else if (pick < 80) begin
         rq.kind = KIND_SEARCH;
      end else if (pick < 95) begin
         rq.kind = KIND_SEED;
         if ($urandom_range(0, 7) != 0) rq.seed_index = 5'($urandom_range(0, WORDS - 1));
         case ($urandom_range(0, 9))
            0: rq.seed_word = '0;
            1: rq.seed_word = '1;
            default: ;
         endcase
      end else begin
         rq.kind = KIND_UNUSED;
      end
      return rq;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      kind_seen[item.kind]++;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (draws_waiting != 0);
   endtask

   // all-zero state: searches run into the zero-count limit across regenerations,
   // then a single live word makes long but finite searches
   task automatic run_sparse_block();
      for (int i = 0; i < WORDS; i++)
         send_request(make_request(KIND_SEED, '0, 1'b0, 5'(i), '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b1, '0, '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd32, 1'b0, '0, '0));
      send_request(make_request(KIND_SEED, '0, 1'b0, 5'($urandom_range(0, WORDS - 1)),
                                $urandom | 32'h1));
      repeat (3) send_request(make_request(KIND_SEARCH, '0, 1'($urandom), '0, '0));
      send_request(make_request(KIND_TAKE, 6'($urandom_range(1, 32)), 1'b0, '0, '0));
      for (int i = 0; i < WORDS; i++)
         send_request(make_request(KIND_SEED, '0, 1'b0, 5'(i), $urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(KIND_TAKE, 6'd1, 1'b1, 5'd31, '1));
      send_request(make_request(KIND_TAKE, 6'd32, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd0, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd63, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd31, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd17, 1'b0, '0, '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b0, '0, '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b1, '0, '0));
      send_request(make_request(KIND_UNUSED, 6'd63, 1'b1, 5'd31, '1));
      // seed index out of range only rewinds the position
      send_request(make_request(KIND_SEED, '0, 1'b0, 5'd31, '1));
      send_request(make_request(KIND_TAKE, 6'd32, 1'b0, '0, '0));
      send_request(make_request(KIND_SEED, '1, 1'b1, 5'd0, '0));
      send_request(make_request(KIND_SEED, '0, 1'b0, 5'd24, '1));
      send_request(make_request(KIND_TAKE, 6'd32, 1'b0, '0, '0));
      send_request(make_request(KIND_TAKE, 6'd32, 1'b0, '0, '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b1, '0, '0));
      send_request(make_request(KIND_SEARCH, '0, 1'b0, '0, '0));
      wait_for_drain();

      for (int n = 0; n < 330; n++) begin
         if (n % 40 == 0) gap_mode = $urandom_range(0, 3);
         if (n == 110 || n == 220) run_sparse_block();
         if (n == 165) wait_for_drain();
         send_request(random_request());
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      $display("requests sent: %0d take, %0d search, %0d seed, %0d unused kind",
               kind_seen[KIND_TAKE], kind_seen[KIND_SEARCH], kind_seen[KIND_SEED],
               kind_seen[KIND_UNUSED]);
      $display("%0d results checked, %0d searches stopped at the zero-count limit",
               draws_checked, search_limit_hits);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ends the run when no transaction moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
